FILE: src/rfml_pkg.sv
`timescale 1ns / 1ps

package rfml_pkg;

  // Operation codes of an input beat
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Register word index of active_routes
  localparam int unsigned REG_ACTIVE_ROUTES = 0;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ACTIVE_W  = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  // One route table entry
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_t;

  // One lookup result
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] index;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_t;

endpackage

FILE: src/rfml_table.sv
`timescale 1ns / 1ps

module rfml_table #(
  parameter int unsigned ROUTES = 16,
  parameter int unsigned IDX_W  = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  rfml_pkg::route_t    wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output rfml_pkg::route_t    rd_data
);

  rfml_pkg::route_t mem [0:ROUTES-1];
  rfml_pkg::route_t rd_data_r;

  // Store one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/rfml_scan.sv
`timescale 1ns / 1ps

module rfml_scan #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          lookup_go,
  input  logic [rfml_pkg::ADDR_W-1:0]   lookup_addr,
  input  logic [CNT_W-1:0]              used,
  output logic                          busy,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  rfml_pkg::route_t              rd_data,
  output logic                          res_valid,
  output rfml_pkg::result_t             res
);

  rfml_pkg::scan_state_t state_r, state_nxt;

  logic [rfml_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]            used_r, used_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            idx_inc;
  logic                        hit;
  logic                        last;
  logic                        res_valid_r, res_valid_nxt;
  rfml_pkg::result_t           res_r, res_nxt;

  assign idx_inc = idx_r + CNT_W'(1);
  assign hit     = ((addr_r ^ rd_data.dest) & rd_data.mask) == '0;
  assign last    = idx_inc == used_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfml_pkg::ST_IDLE: begin
        if (lookup_go && used != '0) begin
          state_nxt = rfml_pkg::ST_SCAN;
        end
      end
      rfml_pkg::ST_SCAN: begin
        if (hit || last) begin
          state_nxt = rfml_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfml_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    addr_nxt      = addr_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    busy          = 1'b0;
    case (state_r)
      rfml_pkg::ST_IDLE: begin
        if (lookup_go) begin
          addr_nxt = lookup_addr;
          used_nxt = used;
          idx_nxt  = '0;
          // Read slot zero now; an empty table misses at once
          rd_en    = used != '0;
          if (used == '0) begin
            res_valid_nxt = 1'b1;
            res_nxt       = '0;
          end
        end
      end
      rfml_pkg::ST_SCAN: begin
        busy = 1'b1;
        // Prefetch the next slot while comparing the current one
        rd_en   = !last;
        rd_addr = IDX_W'(idx_inc);
        idx_nxt = idx_inc;
        if (hit) begin
          res_valid_nxt = 1'b1;
          res_nxt.found   = 1'b1;
          res_nxt.index   = rfml_pkg::SLOT_W'(32'(idx_r));
          res_nxt.gateway = rd_data.gateway;
          res_nxt.port    = rd_data.port;
        end else if (last) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '0;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfml_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    used_r <= used_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: src/route_first_match_lookup.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     start / busy                in_operation, in_entry_*, in_lookup_addr
// result    out_valid (one-cycle beat)  out_found, out_match_index, out_gateway, out_out_port
// config    APB psel/penable/pwrite     paddr, pwdata, prdata (active_routes at 0)
//
// A write beat stores its entry in the accept cycle and is done; busy stays low.
// A lookup reads the table one slot per cycle from the single read port, stops at
// the last route in use (min(active_routes, ROUTES)), and ends early on the
// first match; its result beat comes in the cycle after the scan ends.
// Reset clears control state only; the table holds garbage until written.
// The receiver cannot stall; the next item may be started while a result shows.
module route_first_match_lookup #(
  parameter int unsigned ROUTES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [rfml_pkg::SLOT_W-1:0]         in_entry_index,
  input  logic [rfml_pkg::ADDR_W-1:0]         in_entry_dest,
  input  logic [rfml_pkg::ADDR_W-1:0]         in_entry_mask,
  input  logic [rfml_pkg::ADDR_W-1:0]         in_entry_gateway,
  input  logic [rfml_pkg::PORT_W-1:0]         in_entry_port,
  input  logic [rfml_pkg::ADDR_W-1:0]         in_lookup_addr,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [rfml_pkg::SLOT_W-1:0]         out_match_index,
  output logic [rfml_pkg::ADDR_W-1:0]         out_gateway,
  output logic [rfml_pkg::PORT_W-1:0]         out_out_port,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rfml_pkg::APB_AW-1:0]         paddr,
  input  logic [rfml_pkg::APB_DW-1:0]         pwdata,
  output logic [rfml_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int unsigned CNT_W = $clog2(ROUTES + 1);

  logic [rfml_pkg::ACTIVE_W-1:0] active_routes_r, active_routes_nxt;
  logic                          cfg_wr;
  logic                          cfg_hit;
  logic                          accept;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  rfml_pkg::route_t              wr_data;
  logic                          lookup_go;
  logic [CNT_W-1:0]              used;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  rfml_pkg::route_t              rd_data;
  rfml_pkg::result_t             res;

  // Configuration register
  assign pready  = 1'b1;
  assign cfg_hit = paddr == rfml_pkg::APB_AW'(4 * rfml_pkg::REG_ACTIVE_ROUTES);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? rfml_pkg::APB_DW'(active_routes_r) : '0;

  always_comb begin
    active_routes_nxt = active_routes_r;
    if (cfg_wr) begin
      active_routes_nxt = pwdata[rfml_pkg::ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_routes_r <= '0;
    end else begin
      active_routes_r <= active_routes_nxt;
    end
  end

  // Decode an accepted beat; drop writes to slots past the table
  assign accept    = start && !busy;
  assign wr_en     = accept && (in_operation == rfml_pkg::OP_WRITE) &&
                     (32'(in_entry_index) < ROUTES);
  assign wr_addr   = IDX_W'(32'(in_entry_index));
  assign wr_data   = '{dest: in_entry_dest, mask: in_entry_mask,
                       gateway: in_entry_gateway, port: in_entry_port};
  assign lookup_go = accept && (in_operation == rfml_pkg::OP_LOOKUP);

  // Clamp the routes in use to the table size
  assign used = (32'(active_routes_r) > ROUTES) ? CNT_W'(ROUTES) : CNT_W'(active_routes_r);

  rfml_table #(
    .ROUTES (ROUTES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rfml_scan #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_go   (lookup_go),
    .lookup_addr (in_lookup_addr),
    .used        (used),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (out_valid),
    .res         (res)
  );

  assign out_found       = res.found;
  assign out_match_index = res.index;
  assign out_gateway     = res.gateway;
  assign out_out_port    = res.port;

endmodule
